// ===== src/tdc_eu_pkg.sv =====
`timescale 1ns / 1ps

package tdc_eu_pkg;

  // Word layout
  localparam int unsigned WordW    = 32;
  localparam int unsigned TypeW    = 4;
  localparam int unsigned EventW   = 28;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned TimeW    = 21;
  localparam int unsigned TypeLsb  = 28;
  localparam int unsigned ChanLsb  = 21;

  // Channels carried in every result beat
  localparam int unsigned ReportCh = 4;
  localparam int unsigned WatchedChannelsDef = 4;

  // Result beat: 28 + 4*21 + 4 + 1 = 117 bits, padded to 120
  localparam int unsigned ResW     = EventW + ReportCh * TimeW + ReportCh + 1;
  localparam int unsigned ResDataW = ((ResW + 7) / 8) * 8;

  // Word type codes
  localparam logic [TypeW-1:0] TypeDatum  = 4'd0;
  localparam logic [TypeW-1:0] TypeEnd    = 4'd8;
  localparam logic [TypeW-1:0] TypeHeader = 4'd10;

  typedef struct packed {
    logic              is_header;
    logic              is_datum;
    logic              is_close;
    logic              bad_end;
    logic [EventW-1:0] event_num;
    logic [ChanW-1:0]  channel;
    logic [TimeW-1:0]  hit_time;
  } dec_t;

  typedef struct packed {
    logic                            bad_end;
    logic [ReportCh-1:0]             channel_seen;
    logic [ReportCh-1:0][TimeW-1:0]  first_time;
    logic [EventW-1:0]               event_number;
  } res_t;

endpackage

// ===== src/tdc_eu_decode.sv =====
`timescale 1ns / 1ps

module tdc_eu_decode (
  input  logic [tdc_eu_pkg::WordW-1:0] word_i,
  output tdc_eu_pkg::dec_t             dec_o
);
  import tdc_eu_pkg::*;

  logic [TypeW-1:0] word_type;

  assign word_type = word_i[TypeLsb +: TypeW];

  always_comb begin
    dec_o           = '0;
    dec_o.event_num = word_i[EventW-1:0];
    dec_o.channel   = word_i[ChanLsb +: ChanW];
    dec_o.hit_time  = word_i[TimeW-1:0];
    case (word_type)
      TypeHeader: begin
        dec_o.is_header = 1'b1;
      end
      TypeDatum: begin
        dec_o.is_datum = 1'b1;
      end
      TypeEnd: begin
        dec_o.is_close = 1'b1;
      end
      default: begin
        // any unknown type closes the event abnormally
        dec_o.is_close = 1'b1;
        dec_o.bad_end  = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/tdc_eu_track.sv =====
`timescale 1ns / 1ps

module tdc_eu_track #(
  parameter int unsigned WATCHED_CHANNELS = tdc_eu_pkg::WatchedChannelsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  tdc_eu_pkg::dec_t dec_i,
  output tdc_eu_pkg::res_t res_o
);
  import tdc_eu_pkg::*;

  logic [EventW-1:0]           event_q, event_d;
  logic [WATCHED_CHANNELS-1:0] seen_q, seen_d;
  logic [WATCHED_CHANNELS-1:0] hit;
  logic [TimeW-1:0]            min_q [WATCHED_CHANNELS];

  // one lane per watched channel; channels above the range hit no lane
  for (genvar k = 0; k < WATCHED_CHANNELS; k++) begin : g_lane
    assign hit[k] = dec_i.is_datum && (dec_i.channel == ChanW'(k));

    // an empty lane takes any time, so the minimum needs no reset
    always_ff @(posedge clk_i) begin
      if (adv_i && hit[k] && (!seen_q[k] || (dec_i.hit_time < min_q[k]))) begin
        min_q[k] <= dec_i.hit_time;
      end
    end
  end

  always_comb begin
    event_d = event_q;
    seen_d  = seen_q;
    if (adv_i) begin
      if (dec_i.is_header) begin
        event_d = dec_i.event_num;
      end else if (dec_i.is_datum) begin
        seen_d = seen_q | hit;
      end else begin
        seen_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_q <= '0;
      seen_q  <= '0;
    end else begin
      event_q <= event_d;
      seen_q  <= seen_d;
    end
  end

  assign res_o.event_number = event_q;
  assign res_o.bad_end      = dec_i.bad_end;

  for (genvar k = 0; k < ReportCh; k++) begin : g_report
    if (k < WATCHED_CHANNELS) begin : g_on
      assign res_o.channel_seen[k] = seen_q[k];
      assign res_o.first_time[k]   = seen_q[k] ? min_q[k] : '0;
    end else begin : g_off
      assign res_o.channel_seen[k] = 1'b0;
      assign res_o.first_time[k]   = '0;
    end
  end

endmodule

// ===== src/tdc_event_word_unpacker_min.sv =====
`timescale 1ns / 1ps

// Readout word decoder for a time-to-digital converter event stream.
//
// Slave channel: one 32-bit readout word per beat. Header words latch the
// event number, datum words update the earliest time of a watched channel,
// and an end word (or any unknown type) closes the event.
// Master channel: one result beat per closing word, carrying the event
// number, four per-channel earliest times, the seen mask and a bad-end flag.
//
// Throughput: one word per cycle, unless a closing word waits on a full result
// register; decode and compare are combinational between the input register
// and the result register. A closing word passes the input register and then
// the result register before its beat shows on m_axis_tvalid.
//
// Reset clears the event number, the seen mask and both pipeline valid flags.
// When the receiver stalls, the result beat holds in the output register;
// a further closing word then waits in the input register and drops
// s_axis_tready until the pending beat is taken. Headers and data keep
// flowing as long as no closing word is blocked.
module tdc_event_word_unpacker_min #(
  parameter int unsigned WATCHED_CHANNELS = tdc_eu_pkg::WatchedChannelsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] word
  input  logic [tdc_eu_pkg::WordW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [27:0] event_number, [48:28] first_time_ch0, [69:49] first_time_ch1,
  // [90:70] first_time_ch2, [111:91] first_time_ch3, [115:112] channel_seen,
  // [116] bad_end, [119:117] zero
  output logic [tdc_eu_pkg::ResDataW-1:0] m_axis_tdata
);
  import tdc_eu_pkg::*;

  logic             in_valid_q;
  logic [WordW-1:0] in_word_q;
  logic             out_valid_q, out_valid_d;
  res_t             out_res_q;
  dec_t             dec;
  res_t             res;
  logic             out_free;
  logic             adv;

  // Input register: take a new word whenever it is empty or the held one moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata;
    end
  end

  tdc_eu_decode u_decode (
    .word_i (in_word_q),
    .dec_o  (dec)
  );

  // Advance the held word unless it closes an event and the result slot is full
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && (!dec.is_close || out_free);
  assign s_axis_tready = !in_valid_q || adv;

  tdc_eu_track #(
    .WATCHED_CHANNELS (WATCHED_CHANNELS)
  ) u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .dec_i  (dec),
    .res_o  (res)
  );

  // Result register: load on a closing word, drop once the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && dec.is_close) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && dec.is_close) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(ResDataW - ResW)'(0), out_res_q};

  // A result beat appears only after a closing word moved on
  a_rise_from_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && dec.is_close))
    else $error("result beat without a closing word");

  // A blocked closing word must stall the slave side
  a_close_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && dec.is_close && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("closing word not held while result slot is full");

  // Headers and data never leave a result beat behind
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !dec.is_close && out_free) |=> !out_valid_q)
    else $error("result beat from a non-closing word");

endmodule

// ===== sim/tb_tdc_event_word_unpacker_min.sv =====
`timescale 1ns / 1ps

module tb_tdc_event_word_unpacker_min;
  import tdc_eu_pkg::*;

  localparam int unsigned Watched    = 4;
  localparam int unsigned IdleLimit  = 2000;  // cycles without any beat before giving up
  localparam int unsigned DrainWait  = 8;     // margin after the last expected result is taken
  localparam int unsigned MaxReports = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [WordW-1:0]    s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [ResDataW-1:0] m_tdata;

  // Predicted event state
  logic [EventW-1:0]   held_evnum;
  logic [TimeW-1:0]    earliest_stamp [Watched];
  logic [ReportCh-1:0] hit_mask;

  res_t        summary_q [$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  tdc_event_word_unpacker_min #(
    .WATCHED_CHANNELS(Watched)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Wipe the per-event minima and the seen mask, as a closing word does.
  function automatic void clear_minima();
    for (int k = 0; k < Watched; k++) earliest_stamp[k] = '1;
    hit_mask = '0;
  endfunction

  // Advance the predicted state by one accepted word; queue a summary on a close.
  function automatic void track_word(input logic [WordW-1:0] w);
    res_t             r;
    logic [TypeW-1:0] kind;
    logic [ChanW-1:0] ch;
    logic [TimeW-1:0] stamp;
    kind  = w[TypeLsb +: TypeW];
    ch    = w[ChanLsb +: ChanW];
    stamp = w[TimeW-1:0];
    if (kind == TypeHeader) begin
      held_evnum = w[EventW-1:0];
    end else if (kind == TypeDatum) begin
      // Channels past the watched range are dropped
      if (ch < Watched) begin
        if (stamp < earliest_stamp[ch]) earliest_stamp[ch] = stamp;
        hit_mask[ch] = 1'b1;
      end
    end else begin
      r.event_number = held_evnum;
      for (int k = 0; k < ReportCh; k++) begin
        r.first_time[k] = (k < Watched && hit_mask[k]) ? earliest_stamp[k] : '0;
      end
      r.channel_seen = hit_mask;
      r.bad_end      = (kind != TypeEnd);
      summary_q = {summary_q, r};
      clear_minima();
    end
  endfunction

  function automatic void report_field(input string field, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, exp_v, act_v);
      end
    end
  endfunction

  function automatic void check_summary(input logic [ResDataW-1:0] beat);
    res_t got;
    res_t want;
    got = res_t'(beat[ResW-1:0]);
    if (summary_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%0t: unexpected result beat 0x%0h", $realtime, beat);
      end
      return;
    end
    want = summary_q.pop_front();
    report_field("event_number", 32'(want.event_number), 32'(got.event_number));
    report_field("first_time_ch0", 32'(want.first_time[0]), 32'(got.first_time[0]));
    report_field("first_time_ch1", 32'(want.first_time[1]), 32'(got.first_time[1]));
    report_field("first_time_ch2", 32'(want.first_time[2]), 32'(got.first_time[2]));
    report_field("first_time_ch3", 32'(want.first_time[3]), 32'(got.first_time[3]));
    report_field("channel_seen", 32'(want.channel_seen), 32'(got.channel_seen));
    report_field("bad_end", 32'(want.bad_end), 32'(got.bad_end));
    report_field("pad", 32'd0, 32'(beat[ResDataW-1:ResW]));
  endfunction

  // Receiver: check each beat, stall in random bursts unless idling is off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) check_summary(m_tdata);
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up after a long stretch with no beat on either side.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Send one word, with an optional gap before it; valid stays high afterward.
  task automatic send_word(input logic [WordW-1:0] w);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    track_word(w);
    words_sent++;
  endtask

  function automatic logic [WordW-1:0] datum_word(input logic [ChanW-1:0] ch,
                                                  input logic [TimeW-1:0] stamp);
    return {TypeDatum, 2'($urandom()), ch, stamp};
  endfunction

  function automatic logic [TimeW-1:0] rand_stamp();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return TimeW'($urandom_range(0, 15));
      default: return TimeW'($urandom());
    endcase
  endfunction

  // One event: optional header, a handful of data, then a closing word.
  task automatic send_event();
    logic [TypeW-1:0] kind;
    logic [ChanW-1:0] ch;
    int unsigned      n_data;
    if ($urandom_range(0, 9) < 7) send_word({TypeHeader, EventW'($urandom())});
    n_data = $urandom_range(0, 8);
    for (int i = 0; i < n_data; i++) begin
      ch = ($urandom_range(0, 7) == 0) ? ChanW'($urandom()) : ChanW'($urandom_range(0, 3));
      send_word(datum_word(ch, rand_stamp()));
    end
    kind = TypeEnd;
    if ($urandom_range(0, 4) == 0) begin
      do kind = TypeW'($urandom()); while (kind == TypeDatum || kind == TypeHeader);
    end
    send_word({kind, 28'($urandom())});
  endtask

  task automatic test_directed();
    send_word({TypeEnd, 28'h0});                        // close with no header seen
    send_word({TypeHeader, 28'hFFF_FFFF});
    send_word(datum_word(5'd0, 21'h1F_FFFF));           // max stamp still marks seen
    send_word(datum_word(5'd1, 21'h0));
    send_word(datum_word(5'd1, 21'd5));                 // larger stamp does not win
    send_word({TypeDatum, 2'b11, 5'd3, 21'h1_2345});    // reserved bits set
    send_word(datum_word(5'd4, 21'h0));                 // first unwatched channel
    send_word(datum_word(5'd31, 21'h0));
    send_word({TypeEnd, 28'hFFF_FFFF});
    send_word({TypeEnd, 28'h0});                        // event number kept, all empty
    send_word({TypeHeader, 28'h000_0001});
    send_word(datum_word(5'd2, 21'd7));
    send_word({TypeHeader, 28'h123_4567});              // repeated header keeps minima
    send_word(datum_word(5'd2, 21'd3));
    send_word({4'hF, 28'h0});                           // abnormal close
    send_word({4'h1, 28'hABC_DEF0});
    send_word(datum_word(5'd3, 21'h0));
    send_word({4'h7, 28'h0});
    send_word({4'h9, 28'h0});
    send_word({4'hB, 28'h0});
  endtask

  task automatic test_random_events(input int unsigned until_words);
    while (words_sent < until_words) begin
      if ($urandom_range(0, 9) == 0) send_word(WordW'($urandom()));
      else send_event();
    end
  endtask

  // Hold off the sender until every pending result has been taken.
  task automatic test_drain_pause();
    send_event();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (summary_q.size() != 0) @(posedge clk_i);
    send_event();
  endtask

  task automatic test_back_to_back(input int unsigned until_words);
    no_idle = 1'b1;
    test_random_events(until_words);
  endtask

  initial begin
    held_evnum = '0;
    clear_minima();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_events(700);
    test_drain_pause();
    test_random_events(1400);
    test_back_to_back(1900);

    s_tvalid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    mismatches += summary_q.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== tdc_event_word_unpacker_min.f =====
src/tdc_eu_pkg.sv
src/tdc_eu_decode.sv
src/tdc_eu_track.sv
src/tdc_event_word_unpacker_min.sv
sim/tb_tdc_event_word_unpacker_min.sv
